/* rtl/tsgc_pkg.sv */
// Package: constants, types and command/status structs for the segment gap classifier.
package tsgc_pkg;
  localparam int Directions    = 2;
  localparam int IntervalSlots = 16;
  localparam int GapSlots      = 16;
  localparam int DirW  = (Directions > 1) ? $clog2(Directions) : 1;
  localparam int IvW   = $clog2(IntervalSlots);
  localparam int IvCntW = $clog2(IntervalSlots + 1);
  localparam int GapW  = $clog2(GapSlots);
  localparam int GapCntW = $clog2(GapSlots + 1);
  localparam int PassW = $clog2(IntervalSlots + 2);
  localparam int IvAddrW = $clog2(Directions * IntervalSlots);

  typedef enum logic [2:0] {
    ST_IN_ORDER = 3'd0, ST_OUT_OF_ORDER = 3'd1, ST_RETRANSMIT = 3'd2,
    ST_OVERLAP = 3'd3, ST_ZERO_LENGTH = 3'd4, ST_RESET = 3'd5
  } seg_status_e;

  typedef enum logic [1:0] {
    GS_OPEN = 2'd0, GS_FILLED = 2'd1, GS_ABANDONED = 2'd2, GS_RETIRED = 2'd3
  } gap_state_e;

  typedef struct packed {
    logic                 stream_start;
    logic [0:0]           direction_index;
    logic [31:0]          packet_number;
    logic [31:0]          seq_number;
    logic [15:0]          payload_length;
    logic                 flag_syn;
    logic                 flag_fin;
    logic                 flag_rst;
  } seg_in_t;

  typedef struct packed {
    logic [31:0] packet_tag;
    logic [2:0]  status;
    logic [32:0] frontier_before;
    logic [32:0] end_sequence;
    logic        gap_ahead;
    logic        filled_any;
    logic        gap_recorded;
    logic [4:0]  gaps_filled;
    logic [4:0]  gaps_abandoned;
    logic        store_overflow;
  } seg_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item, classify
    logic iv_chk;     // compare read interval with frontier
    logic pass_clr;   // clear moved flag
    logic commit_fr;  // write closed frontier
    logic gap_chk;    // process gap entry gap_idx
    logic [IvW-1:0]  iv_idx;
    logic [GapW-1:0] gap_idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0]       status;
    logic             moved;
    logic [IvCntW-1:0] iv_cnt;
    logic [GapCntW-1:0] gap_cnt;
  } dp_sts_t;
endpackage

/* rtl/tcp_segment_gap_classifier_core.sv */
// Top level: TCP segment gap classifier core.
// channel | dir | tdata fields (low bit up)                        | tuser fields (low bit up)
// s_axis  | in  | packet_number, seq_number, payload_length (80)   | stream_start, direction_index,
//         |     |                                                  | flag_syn, flag_fin, flag_rst
// m_axis  | out | packet_tag, status, frontier_before, end_sequence,| gap_ahead, filled_any,
//         |     | gaps_filled, gaps_abandoned (111, padded to 112)  | gap_recorded, store_overflow
// Closure runs for in_order/overlap only: up to 17 passes over 16 intervals, with a RAM read
// then a check per interval; gap scan covers max(1, gap count) entries.
// Reset clears frontiers, fill counts and the gap count; stores need no clearing.
// A result waits in its register until taken; the next item is accepted after that.
module tcp_segment_gap_classifier_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [79:0]  s_axis_tdata_i,  // packet_number, seq_number, payload_length
  input  logic [4:0]   s_axis_tuser_i,  // stream_start, direction_index, syn, fin, rst
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [111:0] m_axis_tdata_o,  // tag, status, fr_before, end_seq, filled, abandoned
  output logic [3:0]   m_axis_tuser_o   // gap_ahead, filled_any, gap_recorded, store_overflow
);
  import tsgc_pkg::*;

  seg_in_t  seg;
  seg_out_t res;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  assign seg.packet_number   = s_axis_tdata_i[31:0];
  assign seg.seq_number      = s_axis_tdata_i[63:32];
  assign seg.payload_length  = s_axis_tdata_i[79:64];
  assign seg.stream_start    = s_axis_tuser_i[0];
  assign seg.direction_index = s_axis_tuser_i[1];
  assign seg.flag_syn        = s_axis_tuser_i[2];
  assign seg.flag_fin        = s_axis_tuser_i[3];
  assign seg.flag_rst        = s_axis_tuser_i[4];

  tsgc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i), .in_ready_o (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o), .out_ready_i (m_axis_tready_i),
    .sts_i (sts), .cmd_o (cmd)
  );

  tsgc_datapath u_dp (
    .clk_i, .rst_ni, .in_i (seg), .cmd_i (cmd), .sts_o (sts), .res_o (res)
  );

  assign m_axis_tdata_o = {1'b0, res.gaps_abandoned, res.gaps_filled, res.end_sequence,
                           res.frontier_before, res.status, res.packet_tag};
  assign m_axis_tuser_o = {res.store_overflow, res.gap_recorded, res.filled_any,
                           res.gap_ahead};
endmodule

/* rtl/tsgc_ram.sv */
// Generic single-port-write, registered-read RAM.
module tsgc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/tsgc_datapath.sv */
// Datapath: frontier, interval memory, gap table and result assembly.
module tsgc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsgc_pkg::seg_in_t in_i,
  input  tsgc_pkg::dp_cmd_t cmd_i,
  output tsgc_pkg::dp_sts_t sts_o,
  output tsgc_pkg::seg_out_t res_o
);
  import tsgc_pkg::*;

  logic [32:0]        frontier_q [Directions];
  logic               init_q [Directions];
  logic [IvCntW-1:0]  ivfill_q [Directions];
  logic [32:0]        gap_lo_q [GapSlots];
  logic [31:0]        gap_hi_q [GapSlots];
  gap_state_e         gap_meta_q [GapSlots];
  logic [DirW-1:0]    gap_dir_q [GapSlots];
  logic [GapCntW-1:0] gapfill_q;

  seg_in_t     it_q;
  logic [DirW-1:0] d_q;
  logic [32:0] exp_q;
  seg_out_t    res_q;
  logic        moved_q, dup_q;

  logic [DirW-1:0] d_in;
  logic [16:0]     consumed;
  logic [32:0]     endseq_in, fr_in;
  logic            init_in;

  assign d_in = DirW'(32'(in_i.direction_index) % Directions);
  assign consumed = in_i.flag_rst ? 17'd0 :
                    17'(in_i.payload_length) + 17'(in_i.flag_syn) + 17'(in_i.flag_fin);
  assign endseq_in = 33'(in_i.seq_number) + 33'(consumed);
  assign init_in = in_i.stream_start ? 1'b0 : init_q[d_in];
  assign fr_in   = init_in ? frontier_q[d_in] : 33'(in_i.seq_number);

  // interval RAM: address {dir, slot}
  logic [64:0]        iv_rdata;
  logic               iv_we;
  logic [IvAddrW-1:0] iv_waddr, iv_raddr;
  logic [IvCntW-1:0]  ivf_in;
  logic               iv_full;
  assign ivf_in   = (in_i.stream_start) ? '0 : ivfill_q[d_in];
  assign iv_full  = ivf_in >= IvCntW'(IntervalSlots);
  assign iv_we    = cmd_i.load && !in_i.flag_rst && consumed != 0 &&
                    endseq_in > fr_in && !iv_full;
  assign iv_waddr = IvAddrW'(32'(d_in) * IntervalSlots + 32'(ivf_in[IvW-1:0]));
  assign iv_raddr = IvAddrW'(32'(d_q) * IntervalSlots + 32'(cmd_i.iv_idx));

  tsgc_ram #(.Width(65), .Depth(Directions * IntervalSlots)) u_iv_ram (
    .clk_i   (clk_i),
    .we_i    (iv_we),
    .waddr_i (iv_waddr),
    .wdata_i ({endseq_in, in_i.seq_number}),
    .raddr_i (iv_raddr),
    .rdata_o (iv_rdata)
  );

  logic [31:0] rlo;
  logic [32:0] rhi;
  assign rlo = iv_rdata[31:0];
  assign rhi = iv_rdata[64:32];

  logic    gap_match, gdir;
  gap_state_e gm;
  assign gm = gap_meta_q[cmd_i.gap_idx];
  assign gdir = gap_dir_q[cmd_i.gap_idx] == d_q;
  assign gap_match = gdir && (gm == GS_OPEN || gm == GS_FILLED) &&
                     gap_lo_q[cmd_i.gap_idx] == exp_q &&
                     33'(gap_hi_q[cmd_i.gap_idx]) == 33'(it_q.seq_number);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Directions; k++) begin
        frontier_q[k] <= '0;
        init_q[k]     <= 1'b0;
        ivfill_q[k]   <= '0;
      end
      gapfill_q <= '0;
      moved_q   <= 1'b0;
      dup_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (in_i.stream_start) begin
          for (int k = 0; k < Directions; k++) begin
            frontier_q[k] <= '0;
            init_q[k]     <= 1'b0;
            ivfill_q[k]   <= '0;
          end
          gapfill_q <= '0;
        end
        dup_q <= 1'b0;
        if (in_i.flag_rst) begin
          frontier_q[d_in] <= '0;
          init_q[d_in]     <= 1'b0;
          ivfill_q[d_in]   <= '0;
        end else if (consumed != 0) begin
          frontier_q[d_in] <= fr_in;
          init_q[d_in]     <= 1'b1;
          if (iv_we) begin
            ivfill_q[d_in] <= ivf_in + 1'b1;
          end
        end
      end
      if (cmd_i.pass_clr) begin
        moved_q <= 1'b0;
      end
      if (cmd_i.iv_chk && 33'(rlo) <= exp_q && exp_q < rhi) begin
        moved_q <= 1'b1;
      end
      if (cmd_i.commit_fr) begin
        frontier_q[d_q] <= exp_q;
      end
      if (cmd_i.gap_chk && res_q.status == ST_OUT_OF_ORDER) begin
        if (32'(cmd_i.gap_idx) < 32'(gapfill_q) && gap_match) begin
          dup_q <= 1'b1;
        end
        if (32'(cmd_i.gap_idx) == GapSlots - 1 || 32'(cmd_i.gap_idx) + 1 >= 32'(gapfill_q)) begin
          if (!dup_q && !(32'(cmd_i.gap_idx) < 32'(gapfill_q) && gap_match) &&
              gapfill_q < GapCntW'(GapSlots)) begin
            gapfill_q <= gapfill_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q  <= in_i;
      d_q   <= d_in;
      exp_q <= fr_in;
      res_q.packet_tag      <= in_i.packet_number;
      res_q.frontier_before <= fr_in;
      res_q.end_sequence    <= endseq_in;
      res_q.gap_ahead       <= 1'b0;
      res_q.filled_any      <= 1'b0;
      res_q.gap_recorded    <= 1'b0;
      res_q.gaps_filled     <= '0;
      res_q.gaps_abandoned  <= '0;
      res_q.store_overflow  <= 1'b0;
      if (in_i.flag_rst) begin
        res_q.status <= ST_RESET;
      end else if (consumed == 0) begin
        res_q.status <= ST_ZERO_LENGTH;
      end else if (endseq_in <= fr_in) begin
        res_q.status <= ST_RETRANSMIT;
      end else if (33'(in_i.seq_number) <= fr_in) begin
        res_q.status <= (33'(in_i.seq_number) < fr_in) ? ST_OVERLAP : ST_IN_ORDER;
        res_q.store_overflow <= iv_full;
      end else begin
        res_q.status <= ST_OUT_OF_ORDER;
        res_q.gap_ahead <= 1'b1;
        res_q.store_overflow <= iv_full;
      end
    end
    if (cmd_i.iv_chk && 33'(rlo) <= exp_q && exp_q < rhi) begin
      exp_q <= rhi;
    end
    if (cmd_i.gap_chk) begin
      case (res_q.status)
        ST_RESET: begin
          if (32'(cmd_i.gap_idx) < 32'(gapfill_q) && gdir) begin
            if (gm == GS_OPEN) begin
              gap_meta_q[cmd_i.gap_idx] <= GS_ABANDONED;
              res_q.gaps_abandoned <= res_q.gaps_abandoned + 1'b1;
            end else if (gm == GS_FILLED) begin
              gap_meta_q[cmd_i.gap_idx] <= GS_RETIRED;
            end
          end
        end
        ST_IN_ORDER, ST_OVERLAP: begin
          if (32'(cmd_i.gap_idx) < 32'(gapfill_q) && gdir && gm == GS_OPEN &&
              exp_q >= 33'(gap_hi_q[cmd_i.gap_idx])) begin
            gap_meta_q[cmd_i.gap_idx] <= GS_FILLED;
            res_q.gaps_filled <= res_q.gaps_filled + 1'b1;
            res_q.filled_any  <= 1'b1;
          end
        end
        ST_OUT_OF_ORDER: begin
          if (32'(cmd_i.gap_idx) == GapSlots - 1 ||
              32'(cmd_i.gap_idx) + 1 >= 32'(gapfill_q)) begin
            if (!dup_q && !(32'(cmd_i.gap_idx) < 32'(gapfill_q) && gap_match)) begin
              if (gapfill_q < GapCntW'(GapSlots)) begin
                gap_lo_q[gapfill_q[GapW-1:0]]   <= exp_q;
                gap_hi_q[gapfill_q[GapW-1:0]]   <= it_q.seq_number;
                gap_meta_q[gapfill_q[GapW-1:0]] <= GS_OPEN;
                gap_dir_q[gapfill_q[GapW-1:0]]  <= d_q;
                res_q.gap_recorded <= 1'b1;
              end else begin
                res_q.store_overflow <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.status  = res_q.status;
  assign sts_o.moved   = moved_q;
  assign sts_o.iv_cnt  = ivfill_q[d_q];
  assign sts_o.gap_cnt = gapfill_q;
  assign res_o = res_q;
endmodule

/* rtl/tsgc_ctrl.sv */
// Controller: sequences classification, frontier closure passes and gap table scan.
module tsgc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tsgc_pkg::dp_sts_t sts_i,
  output tsgc_pkg::dp_cmd_t cmd_o
);
  import tsgc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PASS, S_RD, S_CHK, S_GAP, S_DONE
  } state_e;

  state_e state_q;
  logic [IvW-1:0]  iv_q;
  logic [GapW-1:0] gp_q;
  logic [PassW-1:0] pass_q;
  logic out_valid_q;
  logic closure;

  assign closure = sts_i.status == ST_IN_ORDER || sts_i.status == ST_OVERLAP;
  assign in_ready_o  = state_q == S_IDLE && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.iv_idx  = iv_q;
    cmd_o.gap_idx = gp_q;
    cmd_o.load    = in_valid_i && in_ready_o;
    cmd_o.pass_clr = state_q == S_PASS;
    cmd_o.iv_chk  = state_q == S_CHK;
    cmd_o.gap_chk = state_q == S_GAP;
    cmd_o.commit_fr = state_q == S_PASS && closure &&
                      (!sts_i.moved || 32'(pass_q) > IntervalSlots);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iv_q <= '0;
      gp_q <= '0;
      pass_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            state_q <= S_PASS;
            pass_q <= '0;
          end
        end
        S_PASS: begin
          // moved flag holds whether the previous pass advanced
          iv_q <= '0;
          gp_q <= '0;
          if (!closure) begin
            state_q <= (sts_i.status == ST_RESET || sts_i.status == ST_OUT_OF_ORDER) ?
                       S_GAP : S_DONE;
          end else if ((pass_q != 0 && !sts_i.moved) || 32'(pass_q) > IntervalSlots ||
                       sts_i.iv_cnt == 0) begin
            state_q <= S_GAP;
          end else begin
            state_q <= S_RD;
            pass_q <= pass_q + 1'b1;
          end
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (32'(iv_q) + 1 >= 32'(sts_i.iv_cnt)) begin
            state_q <= S_PASS;
          end else begin
            iv_q <= iv_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_GAP: begin
          if (32'(gp_q) == GapSlots - 1 || 32'(gp_q) + 1 >= 32'(sts_i.gap_cnt)) begin
            state_q <= S_DONE;
          end else begin
            gp_q <= gp_q + 1'b1;
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> out_valid_o) else $error("result not raised");
  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> $past(state_q) == S_RD) else $error("check without read");
endmodule
